// File: hw/rtl/wbps_pkg.sv
package wbps_pkg;

    // scan geometry
    localparam int MAX_PATTERN_DEF = 32;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int PATTERN_BYTES   = 32;
    localparam int BYTE_W          = 8;
    localparam int OFFSET_W        = 32;
    localparam int LEN_W           = 6;
    localparam int MASK_W          = 32;

    // configuration port
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 6;
    localparam int PWORD_COUNT = 4;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    typedef enum logic [2:0] {
        REG_PATTERN_0 = 3'd0,
        REG_PATTERN_1 = 3'd1,
        REG_PATTERN_2 = 3'd2,
        REG_PATTERN_3 = 3'd3,
        REG_WILD_MASK = 3'd4,
        REG_PAT_LEN   = 3'd5
    } t_reg_idx;

    // pattern setup as seen by the scanner
    typedef struct packed {
        logic [PATTERN_BYTES-1:0][BYTE_W-1:0] pattern;
        logic [PATTERN_BYTES-1:0]             wild;
        logic [LEN_W-1:0]                     length;
    } t_cfg;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } t_result;

endpackage

// File: hw/rtl/wbps_if.sv
interface wbps_in_if import wbps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if import wbps_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                found;
    logic [OFFSET_W-1:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// File: hw/rtl/wildcard_byte_pattern_search_core.sv
// channel   | dir | handshake     | payload
// i_scan    | in  | valid / ready | data_byte[7:0], last_byte
// o_result  | out | valid / ready | found, match_offset[31:0]
// apb cfg   | in  | psel/penable  | paddr[5:0] (reg at 8*i), pwdata/prdata[63:0]
//
// one byte transfer per cycle while ready is high; its result is buffered on that edge
// the masked compare of the whole window runs between the window and the result register
// reset is synchronous: clears count, match flag, buffers; pattern length resets to 1
// a two-entry result buffer sits on the output; i_scan.ready drops only when both are full
module wildcard_byte_pattern_search_core import wbps_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wbps_in_if.sink               i_scan,
    wbps_out_if.source            o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg    cfg;
    t_result scan_res;
    t_result buf_res;
    logic    scan_valid;
    logic    can_accept;
    logic    accept;

    assign pready       = 1'b1;
    assign i_scan.ready = can_accept;
    assign accept       = i_scan.valid && can_accept;

    // configuration registers
    wbps_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    // window and compare
    wbps_scan #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_data      (i_scan.data_byte),
        .i_last      (i_scan.last_byte),
        .o_res_valid (scan_valid),
        .o_res       (scan_res)
    );

    // result register and skid
    wbps_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (scan_valid),
        .i_res        (scan_res),
        .o_can_accept (can_accept),
        .o_valid      (o_result.valid),
        .i_ready      (o_result.ready),
        .o_res        (buf_res)
    );

    assign o_result.found        = buf_res.found;
    assign o_result.match_offset = buf_res.match_offset;

endmodule

// File: hw/rtl/wbps_cfg.sv
module wbps_cfg import wbps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output t_cfg                  o_cfg
);

    logic [APB_DATA_W-1:0] r_pword [PWORD_COUNT];
    logic [MASK_W-1:0]     r_wild;
    logic [LEN_W-1:0]      r_len;
    logic                  wr_en;
    t_reg_idx              reg_idx;

    assign wr_en   = i_psel && i_penable && i_pwrite;
    assign reg_idx = t_reg_idx'(i_paddr[5:3]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < PWORD_COUNT; w++) begin
                r_pword[w] <= '0;
            end
            r_wild <= '0;
            r_len  <= LEN_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PATTERN_0: r_pword[0] <= i_pwdata;
                REG_PATTERN_1: r_pword[1] <= i_pwdata;
                REG_PATTERN_2: r_pword[2] <= i_pwdata;
                REG_PATTERN_3: r_pword[3] <= i_pwdata;
                REG_WILD_MASK: r_wild     <= i_pwdata[MASK_W-1:0];
                REG_PAT_LEN:   r_len      <= i_pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            REG_PATTERN_0: o_prdata = r_pword[0];
            REG_PATTERN_1: o_prdata = r_pword[1];
            REG_PATTERN_2: o_prdata = r_pword[2];
            REG_PATTERN_3: o_prdata = r_pword[3];
            REG_WILD_MASK: o_prdata = APB_DATA_W'(r_wild);
            REG_PAT_LEN:   o_prdata = APB_DATA_W'(r_len);
            default:       o_prdata = '0;
        endcase
    end

    // byte j of the pattern sits in word j/8, little-endian
    always_comb begin
        for (int j = 0; j < PATTERN_BYTES; j++) begin
            o_cfg.pattern[j] = r_pword[j / 8][8 * (j % 8) +: BYTE_W];
        end
        o_cfg.wild   = r_wild;
        o_cfg.length = r_len;
    end

endmodule

// File: hw/rtl/wbps_scan.sv
module wbps_scan import wbps_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_data,
    input  logic              i_last,
    output logic              o_res_valid,
    output t_result           o_res
);

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = 7;
    localparam int CW = (OFFSET_BITS > OFFSET_W) ? OFFSET_BITS : OFFSET_W;
    localparam logic [OFFSET_BITS-1:0] CNT_MAX = '1;

    logic [BYTE_W-1:0]      r_window [MAX_PATTERN];
    logic [BYTE_W-1:0]      win_next [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] r_count;
    logic                   r_matched;
    logic [OFFSET_BITS-1:0] n_count;
    logic [LW-1:0]          len_raw;
    logic [LW-1:0]          len;
    logic [MAX_PATTERN-1:0] pos_ok;
    logic                   can_match;
    logic                   hit_now;
    logic [OFFSET_BITS-1:0] diff;
    logic [CW-1:0]          diff_ext;

    // effective length: zero acts as one, clamp to window depth
    assign len_raw = LW'(i_cfg.length);
    always_comb begin
        if (len_raw == '0) begin
            len = LW'(1);
        end else if (len_raw > LW'(MAX_PATTERN)) begin
            len = LW'(MAX_PATTERN);
        end else begin
            len = len_raw;
        end
    end

    // window after this byte, entry 0 newest
    assign win_next[0] = i_data;
    for (genvar k = 1; k < MAX_PATTERN; k++) begin : g_shift
        assign win_next[k] = r_window[k-1];
    end

    // one masked compare per pattern position
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cmp
        logic [LW-1:0]     idx;
        logic [BYTE_W-1:0] pbyte;
        logic              wild;
        assign idx = len - LW'(j) - LW'(1);
        if (j < PATTERN_BYTES) begin : g_cfgd
            assign pbyte = i_cfg.pattern[j];
            assign wild  = i_cfg.wild[j];
        end else begin : g_zero
            assign pbyte = '0;
            assign wild  = 1'b0;
        end
        assign pos_ok[j] = (LW'(j) >= len) || wild || (win_next[idx[IW-1:0]] == pbyte);
    end

    // saturating byte count and start offset
    assign n_count   = (r_count == CNT_MAX) ? r_count : r_count + OFFSET_BITS'(1);
    assign can_match = !r_matched && (n_count >= OFFSET_BITS'(len));
    assign hit_now   = can_match && (&pos_ok);
    assign diff      = n_count - OFFSET_BITS'(len);
    assign diff_ext  = CW'(diff);

    // result of this transfer
    assign o_res_valid        = i_accept && (hit_now || (i_last && !r_matched));
    assign o_res.found        = hit_now;
    assign o_res.match_offset = hit_now ? diff_ext[OFFSET_W-1:0] : '0;

    // window, no reset needed: only entries written in this region are compared
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_window <= win_next;
        end
    end

    // region state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_matched <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_count   <= '0;
                r_matched <= 1'b0;
            end else begin
                r_count   <= n_count;
                r_matched <= r_matched || hit_now;
            end
        end
    end

`ifndef SYNTHESIS
    // only one match per region
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_matched |-> !(o_res_valid && o_res.found))
        else $error("second match reported in one region");

    // region end clears the state
    a_region_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last |=> (r_count == '0) && !r_matched)
        else $error("region state not cleared after last byte");
`endif

endmodule

// File: hw/rtl/wbps_out_buf.sv
module wbps_out_buf import wbps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_can_accept,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop          = r_main_valid && i_ready;
    assign o_can_accept = !r_skid_valid;
    assign o_valid      = r_main_valid;
    assign o_res        = r_main;

    // result register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
                r_main       <= i_res;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                r_main_valid <= 1'b1;
                r_main       <= i_res;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid       <= i_res;
            end
        end
    end

`ifndef SYNTHESIS
    // skid entry never holds data ahead of the main register
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry valid while result register empty");

    // a full buffer holds its skid entry while stalled
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !pop |=> r_skid_valid && $stable(r_skid))
        else $error("skid entry lost while stalled");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

import wbps_pkg::*;

// tracks the scan state of the block and the reports it owes
class search_scoreboard;
    logic [APB_DATA_W-1:0] pat_word [PWORD_COUNT];
    logic [MASK_W-1:0]     wild;
    logic [LEN_W-1:0]      plen;
    logic [BYTE_W-1:0]     window [MAX_PATTERN_DEF];
    logic [OFFSET_W-1:0]   seen;
    bit                    matched;
    t_result               reports_due [$];
    int                    fails;
    int                    hits_checked;
    int                    misses_checked;
    int                    regions;

    function new();
        pat_word[0] = '0;
        pat_word[1] = '0;
        pat_word[2] = '0;
        pat_word[3] = '0;
        wild        = '0;
        plen        = LEN_RESET;
        fails       = 0;
        hits_checked = 0;
        misses_checked = 0;
        regions     = 0;
        clear_region();
    endfunction

    function void clear_region();
        for (int k = 0; k < MAX_PATTERN_DEF; k++) window[k] = '0;
        seen    = '0;
        matched = 1'b0;
    endfunction

    // append a report to the tail of the owed list
    function void owe_report(t_result r);
        reports_due = {reports_due, r};
    endfunction

    // register mirror, same masking as the hardware fields
    function void set_register(t_reg_idx idx, logic [APB_DATA_W-1:0] v);
        case (idx)
            REG_PATTERN_0: pat_word[0] = v;
            REG_PATTERN_1: pat_word[1] = v;
            REG_PATTERN_2: pat_word[2] = v;
            REG_PATTERN_3: pat_word[3] = v;
            REG_WILD_MASK: wild = v[MASK_W-1:0];
            REG_PAT_LEN:   plen = v[LEN_W-1:0];
            default: ;
        endcase
    endfunction

    // zero acts as one, anything above the window acts as the window
    function int eff_length();
        if (plen == 0) return 1;
        if (plen > MAX_PATTERN_DEF) return MAX_PATTERN_DEF;
        return int'(plen);
    endfunction

    function logic [BYTE_W-1:0] pattern_byte(int j);
        logic [APB_DATA_W-1:0] w;
        w = pat_word[j / 8];
        return w[8 * (j % 8) +: 8];
    endfunction

    // one accepted byte transfer: shift, count, compare, close region
    function void absorb_byte(logic [BYTE_W-1:0] d, logic last);
        int      n;
        bit      hit;
        t_result r;
        n = eff_length();
        for (int k = MAX_PATTERN_DEF - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = d;
        if (seen != {OFFSET_W{1'b1}}) seen = seen + 1'b1;
        if (!matched && seen >= OFFSET_W'(n)) begin
            hit = 1'b1;
            for (int j = 0; j < n; j++) begin
                if (!wild[j] && window[n - 1 - j] != pattern_byte(j)) hit = 1'b0;
            end
            if (hit) begin
                matched        = 1'b1;
                r.found        = 1'b1;
                r.match_offset = seen - OFFSET_W'(n);
                owe_report(r);
            end
        end
        if (last) begin
            if (!matched) begin
                r.found        = 1'b0;
                r.match_offset = '0;
                owe_report(r);
            end
            regions++;
            clear_region();
        end
    endfunction

    // one accepted result transfer against the oldest report owed
    function void check_report(logic found, logic [OFFSET_W-1:0] offset);
        t_result e;
        if (reports_due.size() == 0) begin
            $display("%0t: unexpected result, expected none actual found=%0d offset=%0d",
                     $time, found, offset);
            fails++;
            return;
        end
        e = reports_due.pop_front();
        if (e.found) hits_checked++;
        else misses_checked++;
        if (found !== e.found) begin
            $display("%0t: found mismatch, expected %0d actual %0d", $time, e.found, found);
            fails++;
        end
        if (offset !== e.match_offset) begin
            $display("%0t: match_offset mismatch, expected %0d actual %0d",
                     $time, e.match_offset, offset);
            fails++;
        end
    endfunction

    function int pending();
        return reports_due.size();
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 85;
    localparam int SETTLE       = 10;

    logic i_clk;
    logic i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    wbps_in_if  scan_if ();
    wbps_out_if res_if ();

    search_scoreboard sb = new();

    int cycle_count = 0;
    int burst_left  = 0;
    int bytes_sent  = 0;
    int ready_run   = 0;
    bit ready_level = 1'b0;

    wildcard_byte_pattern_search_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_scan   (scan_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run limit of %0d cycles reached with %0d reports owed",
                     CYCLE_LIMIT, sb.pending());
            $display("Some tests failed");
            $finish;
        end
    end

    // result receiver: runs of ready and stall of random length
    always @(negedge i_clk) begin
        if (ready_run == 0) begin
            ready_level = !ready_level;
            if (ready_level)
                ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                       : $urandom_range(1, 8);
            else
                ready_run = $urandom_range(1, 20);
        end
        ready_run--;
        res_if.ready = ready_level;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_report(res_if.found, res_if.match_offset);
    end

    // register write: setup then access
    task automatic apb_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] v);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, v);
    endtask

    task automatic configure(input logic [APB_DATA_W-1:0] w0, input logic [APB_DATA_W-1:0] w1,
                             input logic [APB_DATA_W-1:0] w2, input logic [APB_DATA_W-1:0] w3,
                             input logic [MASK_W-1:0] mask, input logic [LEN_W-1:0] len);
        apb_write(REG_PATTERN_0, w0);
        apb_write(REG_PATTERN_1, w1);
        apb_write(REG_PATTERN_2, w2);
        apb_write(REG_PATTERN_3, w3);
        apb_write(REG_WILD_MASK, APB_DATA_W'(mask));
        apb_write(REG_PAT_LEN, APB_DATA_W'(len));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        burst_left = 0;
    endtask

    // one byte transfer, sent in bursts with gaps between them
    task automatic send_byte(input logic [BYTE_W-1:0] d, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                scan_if.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        scan_if.valid     = 1'b1;
        scan_if.data_byte = d;
        scan_if.last_byte = last;
        do @(posedge i_clk); while (!scan_if.ready);
        sb.absorb_byte(d, last);
        bytes_sent++;
    endtask

    // region: random lead-in, pattern body (maybe cut short or corrupted), random tail
    task automatic send_region(input int pre, input int body, input bit corrupt, input int post);
        int                total;
        int                pos;
        int                flip;
        int                tries;
        logic [BYTE_W-1:0] b;
        total = pre + body + post;
        flip  = -1;
        if (corrupt && body > 0) begin
            for (tries = 0; tries < 64 && flip < 0; tries++) begin
                pos = $urandom_range(0, body - 1);
                if (!sb.wild[pos]) flip = pos;
            end
        end
        for (int k = 0; k < total; k++) begin
            b = BYTE_W'($urandom);
            if (k >= pre && k < pre + body) begin
                pos = k - pre;
                if (!sb.wild[pos]) b = sb.pattern_byte(pos);
                if (pos == flip) b = b ^ BYTE_W'($urandom_range(1, 255));
            end
            send_byte(b, k == total - 1);
        end
    endtask

    // wait for every owed report, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        scan_if.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // random regions under the current setting
    task automatic random_phase(input int budget);
        int start;
        int n;
        int kind;
        int pre;
        int post;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            n    = sb.eff_length();
            kind = $urandom_range(0, 99);
            pre  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            post = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (kind < 60)
                send_region(pre, n, 1'b0, post);
            else if (kind < 75)
                send_region(pre, n, 1'b1, post);
            else if (kind < 88)
                send_region($urandom_range(1, 40), 0, 1'b0, 0);
            else if (n > 1)
                send_region(0, $urandom_range(1, n - 1), 1'b0, 0);
            else
                send_region(1, 0, 1'b0, 0);
        end
        // sometimes leave a region open across the setting change
        if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 5)) send_byte(BYTE_W'($urandom), 1'b0);
        end
    endtask

    function automatic logic [APB_DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    initial begin
        i_rst_n           = 1'b0;
        scan_if.valid     = 1'b0;
        scan_if.data_byte = '0;
        scan_if.last_byte = 1'b0;
        res_if.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    // reset setting: single pattern byte 0x00
                    send_byte(8'hFF, 1'b0);
                    send_byte(8'h00, 1'b0);
                    send_byte(8'h00, 1'b0);
                    send_byte(8'hFF, 1'b1);
                    send_byte(8'hFF, 1'b1);
                    send_byte(8'h00, 1'b1);
                end
                1: begin
                    // zero length behaves as one
                    configure(64'hFFFF_FFFF_FFFF_FFA5, rand_word(), rand_word(), rand_word(),
                              32'h0, 6'd0);
                    send_byte(8'h5A, 1'b0);
                    send_byte(8'hA5, 1'b1);
                    send_byte(8'hA5, 1'b0);
                    send_byte(8'h00, 1'b1);
                end
                2: begin
                    // overlong length, every byte a wildcard
                    configure(rand_word(), rand_word(), rand_word(), rand_word(),
                              32'hFFFF_FFFF, 6'd63);
                    send_region(0, 31, 1'b0, 0);
                    send_region(0, 32, 1'b0, 0);
                    send_region(3, 32, 1'b0, 2);
                end
                3: begin
                    // longest pattern, all ones, no wildcards
                    configure('1, '1, '1, '1, 32'h0, 6'd32);
                    send_region(0, 32, 1'b0, 0);
                    send_region(2, 32, 1'b1, 0);
                end
                4: configure('0, '0, '0, '0, 32'h8000_0001, 6'd32);
                10: configure(rand_word(), rand_word(), rand_word(), rand_word(),
                              $urandom, LEN_W'($urandom_range(33, 63)));
                11: configure(rand_word(), rand_word(), rand_word(), rand_word(),
                              $urandom & $urandom, LEN_W'($urandom_range(1, 32)));
                default: configure(rand_word(), rand_word(), rand_word(), rand_word(),
                                   $urandom & $urandom & $urandom,
                                   LEN_W'($urandom_range(1, 12)));
            endcase
            random_phase(PHASE_ITEMS);
            drain();
        end

        $display("scan run: %0d byte transfers in %0d regions over %0d pattern settings",
                 bytes_sent, sb.regions, PHASES);
        $display("checked %0d match reports and %0d not-found reports",
                 sb.hits_checked, sb.misses_checked);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_if.sv
hw/rtl/wbps_cfg.sv
hw/rtl/wbps_scan.sv
hw/rtl/wbps_out_buf.sv
hw/rtl/wildcard_byte_pattern_search_core.sv
verif/tb_top.sv
